// ===== hw/rtl/fccs_pkg.sv =====
// ----------------------------------------------------------------------------
// fccs_pkg
// shared types, constants and helpers of the frame column color summarizer
// ----------------------------------------------------------------------------
package fccs_pkg;

  localparam int unsigned MAX_SIDE   = 4096;
  localparam int unsigned MAX_COPIES = 63;

  localparam int unsigned SIDE_W  = 13;   // register width of a frame side
  localparam int unsigned AREA_W  = 25;   // holds MAX_SIDE * MAX_SIDE
  localparam int unsigned POS_W   = 24;   // pixel position inside a frame
  localparam int unsigned SUM_W   = 32;   // channel sums
  localparam int unsigned COPY_W  = 6;    // holds MAX_COPIES
  localparam int unsigned COL_W   = 12;   // column counter
  localparam int unsigned ADDR_W  = 4;    // apb byte address

  // divider operand widths
  localparam int unsigned DVD_W = SUM_W;
  localparam int unsigned DVS_W = AREA_W;
  localparam int unsigned CNT_W = $clog2(DVD_W);

  // register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_STRIP  = 2'd3;

  // summary modes
  localparam logic [1:0] MODE_CENTER  = 2'd0;
  localparam logic [1:0] MODE_AVERAGE = 2'd1;
  localparam logic [1:0] MODE_STRIP   = 2'd2;

  // result kinds
  localparam logic KIND_STRIP = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic [7:0] pixel_c0;
    logic [7:0] pixel_c1;
    logic [7:0] pixel_c2;
  } pixel_t;

  typedef struct packed {
    logic [7:0]        color_c0;
    logic [7:0]        color_c1;
    logic [7:0]        color_c2;
    logic [11:0]       strip_row;
    logic [COL_W-1:0]  column_number;
    logic              kind;
    logic [12:0]       rows_written;
    logic              last;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // zero reads as one, anything above the largest side reads as the largest side
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      r = SIDE_W'(MAX_SIDE);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/frame_column_color_summarizer_top.sv =====
// ----------------------------------------------------------------------------
// frame_column_color_summarizer_top
// per-frame summary column: center pixel, frame mean or averaged strip
// ----------------------------------------------------------------------------
// an ordinary pixel passes accept, chunk check and frame check in turn;
// a frame start adds 2 divisions; a chunk end adds 3 divisions and then writes its
// strip rows; a frame end adds a final result, in mode 1 after 3 divisions
// each division runs on the shared divider
// an end-of-frame result with no division follows its pixel via the check, end and final states
// reset clears control and frame state except the means and output payload; ready rises in the cycle after reset
module frame_column_color_summarizer_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  // pixel stream
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  fccs_pkg::pixel_t             in_data_i,

  // summary results
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output fccs_pkg::result_t            out_data_o,

  // apb configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fccs_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DIV_START = 7'b0000010,
    S_DIV_WAIT  = 7'b0000100,
    S_CHECK     = 7'b0001000,
    S_EMIT      = 7'b0010000,
    S_END       = 7'b0100000,
    S_FINAL     = 7'b1000000
  } state_e;

  // which quotient the shared divider is producing
  typedef enum logic [2:0] {
    OP_INTERVAL,
    OP_COPIES,
    OP_CM0,
    OP_CM1,
    OP_CM2,
    OP_FM0,
    OP_FM1,
    OP_FM2
  } op_e;

  // configuration registers
  logic [1:0]                  mode_q;
  logic [fccs_pkg::SIDE_W-1:0] width_q, height_q, strip_q;
  logic                        cfg_wr;
  logic                        settle_q;

  // frame geometry, recomputed every cycle from the registers
  logic [fccs_pkg::SIDE_W-1:0]   w_c, h_c, s_c;
  logic [2*fccs_pkg::SIDE_W-1:0] area_full;
  logic [2*fccs_pkg::SIDE_W-1:0] center_full;
  logic [fccs_pkg::AREA_W-1:0]   area_q;
  logic [fccs_pkg::AREA_W-1:0]   center_pos_q;

  state_e state_q, state_d;
  op_e    op_q, op_d;

  fccs_pkg::pixel_t              center_q, center_d;
  logic [2:0][fccs_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [2:0][7:0]               mean_q, mean_d;
  logic [fccs_pkg::AREA_W-1:0]   chunk_cnt_q, chunk_cnt_d;
  logic [fccs_pkg::AREA_W-1:0]   chunk_len_q, chunk_len_d;
  logic [fccs_pkg::AREA_W-1:0]   interval_q, interval_d;
  logic [fccs_pkg::COPY_W-1:0]   copies_q, copies_d;
  logic [fccs_pkg::COPY_W-1:0]   copy_left_q, copy_left_d;
  logic [fccs_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [fccs_pkg::SIDE_W-1:0]   strip_idx_q, strip_idx_d;
  logic [fccs_pkg::COL_W-1:0]    column_q, column_d;

  logic                          out_valid_q, out_valid_d;
  fccs_pkg::result_t             out_q, out_d;
  logic                          out_free;

  fccs_pkg::div_req_t            div_req;
  fccs_pkg::div_rsp_t            div_rsp;

  logic                          first_px;
  logic                          frame_done;
  logic [fccs_pkg::AREA_W-1:0]   pos_next;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= fccs_pkg::MODE_AVERAGE;
      width_q  <= fccs_pkg::SIDE_W'(1920);
      height_q <= fccs_pkg::SIDE_W'(1080);
      strip_q  <= fccs_pkg::SIDE_W'(1080);
      settle_q <= 1'b1;
    end else begin
      // settle holds input off while the geometry registers follow a write
      settle_q <= cfg_wr;
      if (cfg_wr) begin
        unique case (paddr[3:2])
          fccs_pkg::REG_MODE:   mode_q   <= pwdata[1:0];
          fccs_pkg::REG_WIDTH:  width_q  <= pwdata[fccs_pkg::SIDE_W-1:0];
          fccs_pkg::REG_HEIGHT: height_q <= pwdata[fccs_pkg::SIDE_W-1:0];
          fccs_pkg::REG_STRIP:  strip_q  <= pwdata[fccs_pkg::SIDE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fccs_pkg::REG_MODE:   prdata = {30'd0, mode_q};
      fccs_pkg::REG_WIDTH:  prdata = {{(32-fccs_pkg::SIDE_W){1'b0}}, width_q};
      fccs_pkg::REG_HEIGHT: prdata = {{(32-fccs_pkg::SIDE_W){1'b0}}, height_q};
      fccs_pkg::REG_STRIP:  prdata = {{(32-fccs_pkg::SIDE_W){1'b0}}, strip_q};
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // geometry: area and center position, registered
  // --------------------------------------------------------------------------
  assign w_c = fccs_pkg::clamp_side(width_q);
  assign h_c = fccs_pkg::clamp_side(height_q);
  assign s_c = fccs_pkg::clamp_side(strip_q);

  assign area_full   = w_c * h_c;
  assign center_full = ({1'b0, w_c[fccs_pkg::SIDE_W-1:1]} * h_c)
                     + {{(fccs_pkg::SIDE_W+1){1'b0}}, h_c[fccs_pkg::SIDE_W-1:1]};

  always_ff @(posedge clk_i) begin
    area_q       <= area_full[fccs_pkg::AREA_W-1:0];
    center_pos_q <= center_full[fccs_pkg::AREA_W-1:0];
  end

  // --------------------------------------------------------------------------
  // shared divider
  // --------------------------------------------------------------------------
  fccs_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // operand select by operation
  always_comb begin
    div_req.start = (state_q == S_DIV_START);
    case (op_q)
      OP_INTERVAL: begin
        div_req.dividend = {{(fccs_pkg::DVD_W-fccs_pkg::AREA_W){1'b0}}, area_q};
        div_req.divisor  = {{(fccs_pkg::DVS_W-fccs_pkg::SIDE_W){1'b0}}, s_c};
      end
      OP_COPIES: begin
        div_req.dividend = {{(fccs_pkg::DVD_W-fccs_pkg::AREA_W){1'b0}}, interval_q};
        div_req.divisor  = {{(fccs_pkg::DVS_W-fccs_pkg::SIDE_W){1'b0}}, s_c};
      end
      OP_CM0: begin
        div_req.dividend = sum_q[0];
        div_req.divisor  = chunk_cnt_q;
      end
      OP_CM1: begin
        div_req.dividend = sum_q[1];
        div_req.divisor  = chunk_cnt_q;
      end
      OP_CM2: begin
        div_req.dividend = sum_q[2];
        div_req.divisor  = chunk_cnt_q;
      end
      OP_FM0: begin
        div_req.dividend = sum_q[0];
        div_req.divisor  = area_q;
      end
      OP_FM1: begin
        div_req.dividend = sum_q[1];
        div_req.divisor  = area_q;
      end
      default: begin
        div_req.dividend = sum_q[2];
        div_req.divisor  = area_q;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE) && !settle_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign first_px   = (pos_q == '0);
  assign pos_next   = {1'b0, pos_q} + 1'b1;
  assign frame_done = (pos_next >= area_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    center_d    = center_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    chunk_cnt_d = chunk_cnt_q;
    chunk_len_d = chunk_len_q;
    interval_d  = interval_q;
    copies_d    = copies_q;
    copy_left_d = copy_left_q;
    pos_d       = pos_q;
    strip_idx_d = strip_idx_q;
    column_d    = column_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          // first pixel of a frame restarts sums, chunk and strip
          for (int c = 0; c < 3; c++) begin
            sum_d[c] = first_px ? '0 : sum_q[c];
          end
          sum_d[0] = sum_d[0] + {{(fccs_pkg::SUM_W-8){1'b0}}, in_data_i.pixel_c0};
          sum_d[1] = sum_d[1] + {{(fccs_pkg::SUM_W-8){1'b0}}, in_data_i.pixel_c1};
          sum_d[2] = sum_d[2] + {{(fccs_pkg::SUM_W-8){1'b0}}, in_data_i.pixel_c2};
          if (first_px) begin
            center_d    = '0;
            chunk_cnt_d = '0;
            strip_idx_d = '0;
          end
          if ({1'b0, pos_q} == center_pos_q) begin
            center_d = in_data_i;
          end
          if (mode_q == fccs_pkg::MODE_STRIP) begin
            chunk_cnt_d = chunk_cnt_d + 1'b1;
          end
          if (first_px) begin
            op_d    = OP_INTERVAL;
            state_d = S_DIV_START;
          end else begin
            state_d = S_CHECK;
          end
        end
      end

      S_DIV_START: begin
        state_d = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (op_q)
            OP_INTERVAL: begin
              interval_d  = div_rsp.quotient[fccs_pkg::AREA_W-1:0];
              chunk_len_d = div_rsp.quotient[fccs_pkg::AREA_W-1:0] + 1'b1;
              op_d        = OP_COPIES;
              state_d     = S_DIV_START;
            end
            OP_COPIES: begin
              copies_d = (div_rsp.quotient > fccs_pkg::DVD_W'(fccs_pkg::MAX_COPIES))
                       ? fccs_pkg::COPY_W'(fccs_pkg::MAX_COPIES)
                       : div_rsp.quotient[fccs_pkg::COPY_W-1:0];
              state_d  = S_CHECK;
            end
            OP_CM0: begin
              mean_d[0] = div_rsp.quotient[7:0];
              op_d      = OP_CM1;
              state_d   = S_DIV_START;
            end
            OP_CM1: begin
              mean_d[1] = div_rsp.quotient[7:0];
              op_d      = OP_CM2;
              state_d   = S_DIV_START;
            end
            OP_CM2: begin
              // chunk closed: restart its sums and count, then write copies
              mean_d[2]   = div_rsp.quotient[7:0];
              sum_d       = '0;
              chunk_cnt_d = '0;
              copy_left_d = copies_q;
              state_d     = S_EMIT;
            end
            OP_FM0: begin
              mean_d[0] = (div_rsp.quotient > fccs_pkg::DVD_W'(255)) ? 8'hFF
                        : div_rsp.quotient[7:0];
              op_d      = OP_FM1;
              state_d   = S_DIV_START;
            end
            OP_FM1: begin
              mean_d[1] = (div_rsp.quotient > fccs_pkg::DVD_W'(255)) ? 8'hFF
                        : div_rsp.quotient[7:0];
              op_d      = OP_FM2;
              state_d   = S_DIV_START;
            end
            default: begin
              mean_d[2] = (div_rsp.quotient > fccs_pkg::DVD_W'(255)) ? 8'hFF
                        : div_rsp.quotient[7:0];
              state_d   = S_FINAL;
            end
          endcase
        end
      end

      S_CHECK: begin
        if ((mode_q == fccs_pkg::MODE_STRIP) && (chunk_cnt_q >= chunk_len_q)) begin
          op_d    = OP_CM0;
          state_d = S_DIV_START;
        end else begin
          state_d = S_END;
        end
      end

      S_EMIT: begin
        // copies stop early once the strip column is full
        if ((copy_left_q == '0) || (strip_idx_q >= s_c)) begin
          state_d = S_END;
        end else if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.color_c0      = mean_q[0];
          out_d.color_c1      = mean_q[1];
          out_d.color_c2      = mean_q[2];
          out_d.strip_row     = strip_idx_q[11:0];
          out_d.column_number = column_q;
          out_d.kind          = fccs_pkg::KIND_STRIP;
          out_d.rows_written  = '0;
          out_d.last          = 1'b0;
          strip_idx_d         = strip_idx_q + 1'b1;
          copy_left_d         = copy_left_q - 1'b1;
        end
      end

      S_END: begin
        if (frame_done) begin
          if (mode_q == fccs_pkg::MODE_AVERAGE) begin
            op_d    = OP_FM0;
            state_d = S_DIV_START;
          end else begin
            state_d = S_FINAL;
          end
        end else begin
          pos_d   = pos_next[fccs_pkg::POS_W-1:0];
          state_d = S_IDLE;
        end
      end

      S_FINAL: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.color_c0      = '0;
          out_d.color_c1      = '0;
          out_d.color_c2      = '0;
          out_d.strip_row     = '0;
          out_d.column_number = column_q;
          out_d.kind          = fccs_pkg::KIND_FRAME;
          out_d.rows_written  = '0;
          out_d.last          = 1'b1;
          case (mode_q)
            fccs_pkg::MODE_CENTER: begin
              out_d.color_c0 = center_q.pixel_c0;
              out_d.color_c1 = center_q.pixel_c1;
              out_d.color_c2 = center_q.pixel_c2;
            end
            fccs_pkg::MODE_AVERAGE: begin
              out_d.color_c0 = mean_q[0];
              out_d.color_c1 = mean_q[1];
              out_d.color_c2 = mean_q[2];
            end
            fccs_pkg::MODE_STRIP: begin
              out_d.rows_written = strip_idx_q;
            end
            default: ;  // unknown mode ends the frame with an empty result
          endcase
          column_d = column_q + 1'b1;
          pos_d    = '0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_INTERVAL;
      center_q    <= '0;
      sum_q       <= '0;
      chunk_cnt_q <= '0;
      chunk_len_q <= '0;
      interval_q  <= '0;
      copies_q    <= '0;
      copy_left_q <= '0;
      pos_q       <= '0;
      strip_idx_q <= '0;
      column_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      center_q    <= center_d;
      sum_q       <= sum_d;
      chunk_cnt_q <= chunk_cnt_d;
      chunk_len_q <= chunk_len_d;
      interval_q  <= interval_d;
      copies_q    <= copies_d;
      copy_left_q <= copy_left_d;
      pos_q       <= pos_d;
      strip_idx_q <= strip_idx_d;
      column_q    <= column_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mean_q <= mean_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/fccs_divider.sv =====
// ----------------------------------------------------------------------------
// fccs_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fccs_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fccs_pkg::div_req_t req_i,
  output fccs_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [fccs_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [fccs_pkg::DVS_W-1:0]    rem_q, rem_d;
  logic [fccs_pkg::DVD_W-1:0]    quo_q, quo_d;
  logic [fccs_pkg::DVS_W-1:0]    dvs_q, dvs_d;

  logic [fccs_pkg::DVS_W:0]      shifted;
  logic [fccs_pkg::DVS_W+1:0]    diff;

  assign shifted = {rem_q, quo_q[fccs_pkg::DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // trial subtract, keep the difference when it does not go negative
      if (!diff[fccs_pkg::DVS_W+1]) begin
        rem_d = diff[fccs_pkg::DVS_W-1:0];
        quo_d = {quo_q[fccs_pkg::DVD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[fccs_pkg::DVS_W-1:0];
        quo_d = {quo_q[fccs_pkg::DVD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == fccs_pkg::CNT_W'(fccs_pkg::DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
